### hdl/i2c_master_transaction_sequencer_unit_defines.svh
// Assertion macros shared by the sequencer RTL.
// Expects clk and rst in scope at the point of use; no other dependencies.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define I2CMS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer assertion failed");
`define I2CMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer assertion failed");
`else
`define I2CMS_ASSERT_IMPLIES(label, ante, cons)
`define I2CMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/i2cms_pkg.sv
// Package for the I2C master transaction sequencer: word types, codes, depths.
// No dependencies.
package i2cms_pkg;

  localparam int WRITE_DEPTH = 32;
  localparam int READ_DEPTH  = 32;
  localparam int STORE_AW    = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

  localparam logic [2:0] FN_LOAD       = 3'd0;
  localparam logic [2:0] FN_WRITE      = 3'd1;
  localparam logic [2:0] FN_READ       = 3'd2;
  localparam logic [2:0] FN_WRITE_READ = 3'd3;
  localparam logic [2:0] FN_CLEAR      = 3'd4;
  localparam logic [2:0] FN_EVENT      = 3'd5;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  localparam int EV_STOP   = 0;
  localparam int EV_RX     = 1;
  localparam int EV_TX     = 2;
  localparam int EV_NACK   = 3;
  localparam int EV_ACCESS = 4;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] slave_address;
    logic [5:0] write_count;
    logic [5:0] read_count;
    logic [4:0] buffer_index;
    logic [7:0] byte_value;
    logic [4:0] event_flags;
    logic       bus_busy;
    logic       stop_pending;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] status;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] rx_index;
    logic       cmd_start;
    logic       cmd_stop;
    logic       transmit_mode;
    logic [5:0] byte_count;
    logic [6:0] target_address;
  } out_word_t;

endpackage

### hdl/i2cms_in_if.sv
// Command channel: valid/ready handshake carrying one input word.
// Depends on i2cms_pkg.
interface i2cms_in_if;
  logic                valid;
  logic                ready;
  i2cms_pkg::in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

### hdl/i2cms_out_if.sv
// Result channel: valid/ready handshake carrying one result word.
// Depends on i2cms_pkg.
interface i2cms_out_if;
  logic                 valid;
  logic                 ready;
  i2cms_pkg::out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

### hdl/i2c_master_transaction_sequencer_unit.sv
// I2C master transaction sequencer, top level: command and result channels.
// Depends on i2cms_pkg, i2cms_in_if, i2cms_out_if, i2cms_seq and the defines header.
//
// Usage: each command word (load byte, start write/read/write-read, clear,
// controller event) on the command channel yields exactly one result word on
// the result channel, in order. A command is taken into an input register,
// evaluated combinationally against the transfer state, and lands in the result
// register; each word passes through the input register, then the result register.
// Throughput is one word per cycle: the input register and the result register
// both advance in the same cycle whenever the result register is empty or its
// word is being taken, and the transfer state is updated at that same edge.
// When the receiver stalls, the result word holds, the input register holds
// one further word, and command ready drops until the result is taken.
// Synchronous reset empties both registers and returns the transfer state to
// idle with zero counts, positions and address; the write byte store keeps its
// contents and must be loaded before it is sent.
`include "i2c_master_transaction_sequencer_unit_defines.svh"

module i2c_master_transaction_sequencer_unit (
  input logic         clk,
  input logic         rst,
  i2cms_in_if.sink    command,
  i2cms_out_if.source result
);

  logic                 held_valid;
  i2cms_pkg::in_word_t  held;
  logic                 result_valid;
  i2cms_pkg::out_word_t result_word;
  i2cms_pkg::out_word_t result_next;
  logic                 advance;

  assign advance       = held_valid && (!result_valid || result.ready);
  assign command.ready = !held_valid || advance;
  assign result.valid  = result_valid;
  assign result.word   = result_word;

  i2cms_seq seq (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (held),
    .res  (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (command.ready) begin
      held_valid <= command.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (command.valid && command.ready) begin
      held <= command.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_word <= result_next;
    end
  end

  `I2CMS_ASSERT_IMPLIES(a_start_has_count, result_valid && result_word.cmd_start,
                        result_word.byte_count != 6'd0)
  `I2CMS_ASSERT_IMPLIES(a_one_byte_dir, result_valid,
                        !(result_word.rx_valid && result_word.tx_valid))
  `I2CMS_ASSERT_IMPLIES(a_accept_no_data, result_valid && result_word.accepted,
                        !result_word.rx_valid && !result_word.tx_valid)
  `I2CMS_ASSERT_NEXT(a_held_kept, held_valid && !advance, held_valid && $stable(held))

endmodule

### hdl/i2cms_seq.sv
// Transfer state, write byte store and next-state/result logic of the sequencer.
// Depends on i2cms_pkg.
module i2cms_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  i2cms_pkg::in_word_t  cmd,
  output i2cms_pkg::out_word_t res
);

  logic [1:0] status;
  logic       direction;
  logic [5:0] active_count;
  logic [5:0] write_position;
  logic [5:0] read_position;
  logic [5:0] deferred_count;
  logic       armed;
  logic [6:0] address;
  logic [7:0] store [i2cms_pkg::WRITE_DEPTH];

  logic [1:0] status_next;
  logic       direction_next;
  logic [5:0] active_count_next;
  logic [5:0] write_position_next;
  logic [5:0] read_position_next;
  logic [5:0] deferred_count_next;
  logic       armed_next;
  logic [6:0] address_next;

  logic can_start;
  logic write_ok;
  logic read_ok;
  logic load_ok;
  logic nack;

  assign can_start = (status != i2cms_pkg::ST_BUSY) && !cmd.bus_busy && !cmd.stop_pending;
  assign write_ok  = (cmd.write_count != 6'd0) &&
                     (32'(cmd.write_count) <= 32'(i2cms_pkg::WRITE_DEPTH));
  assign read_ok   = (cmd.read_count != 6'd0) &&
                     (32'(cmd.read_count) <= 32'(i2cms_pkg::READ_DEPTH));
  assign load_ok   = (cmd.func == i2cms_pkg::FN_LOAD) &&
                     (32'(cmd.buffer_index) < 32'(i2cms_pkg::WRITE_DEPTH));
  assign nack      = cmd.event_flags[i2cms_pkg::EV_NACK];

  always_comb begin
    status_next         = status;
    direction_next      = direction;
    active_count_next   = active_count;
    write_position_next = write_position;
    read_position_next  = read_position;
    deferred_count_next = deferred_count;
    armed_next          = armed;
    address_next        = address;
    res                 = '0;

    unique case (cmd.func)
      i2cms_pkg::FN_LOAD: begin
      end
      i2cms_pkg::FN_WRITE: begin
        if (can_start && write_ok) begin
          res.accepted        = 1'b1;
          status_next         = i2cms_pkg::ST_BUSY;
          direction_next      = 1'b1;
          address_next        = cmd.slave_address;
          write_position_next = 6'd0;
          active_count_next   = cmd.write_count;
          armed_next          = 1'b0;
          res.cmd_start       = 1'b1;
          res.cmd_stop        = 1'b1;
          res.byte_count      = cmd.write_count;
        end
      end
      i2cms_pkg::FN_READ: begin
        if (can_start && read_ok) begin
          res.accepted       = 1'b1;
          status_next        = i2cms_pkg::ST_BUSY;
          direction_next     = 1'b0;
          address_next       = cmd.slave_address;
          read_position_next = 6'd0;
          active_count_next  = cmd.read_count;
          armed_next         = 1'b0;
          res.cmd_start      = 1'b1;
          res.cmd_stop       = 1'b1;
          res.byte_count     = cmd.read_count;
        end
      end
      i2cms_pkg::FN_WRITE_READ: begin
        if (can_start && write_ok && read_ok) begin
          res.accepted        = 1'b1;
          status_next         = i2cms_pkg::ST_BUSY;
          direction_next      = 1'b1;
          address_next        = cmd.slave_address;
          write_position_next = 6'd0;
          read_position_next  = 6'd0;
          active_count_next   = cmd.write_count;
          deferred_count_next = cmd.read_count;
          armed_next          = 1'b1;
          res.cmd_start       = 1'b1;
          res.byte_count      = cmd.write_count;
        end
      end
      i2cms_pkg::FN_CLEAR: begin
        if (status != i2cms_pkg::ST_BUSY) begin
          status_next  = i2cms_pkg::ST_IDLE;
          res.accepted = 1'b1;
        end
      end
      i2cms_pkg::FN_EVENT: begin
        if (cmd.event_flags[i2cms_pkg::EV_STOP]) begin
          if (status == i2cms_pkg::ST_BUSY) begin
            status_next = i2cms_pkg::ST_DONE;
          end
        end else if (!direction && cmd.event_flags[i2cms_pkg::EV_RX] &&
                     (read_position < active_count)) begin
          res.rx_valid       = 1'b1;
          res.rx_byte        = cmd.byte_value;
          res.rx_index       = read_position[4:0];
          read_position_next = read_position + 6'd1;
        end else if (direction && cmd.event_flags[i2cms_pkg::EV_TX] &&
                     (write_position < active_count)) begin
          res.tx_valid = 1'b1;
          if (32'(write_position) < 32'(i2cms_pkg::WRITE_DEPTH)) begin
            res.tx_byte = store[i2cms_pkg::STORE_AW'(write_position)];
          end
          write_position_next = write_position + 6'd1;
        end else if (nack) begin
          res.cmd_stop = 1'b1;
          status_next  = i2cms_pkg::ST_ERR;
        end
        if (cmd.event_flags[i2cms_pkg::EV_ACCESS] && !nack && armed) begin
          armed_next        = 1'b0;
          direction_next    = 1'b0;
          active_count_next = deferred_count;
          res.cmd_start     = 1'b1;
          res.cmd_stop      = 1'b1;
          res.byte_count    = deferred_count;
        end
      end
      default: begin
      end
    endcase

    res.status         = cmd.stop_pending ? i2cms_pkg::ST_BUSY : status_next;
    res.transmit_mode  = direction_next;
    res.target_address = address_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status         <= i2cms_pkg::ST_IDLE;
      direction      <= 1'b0;
      active_count   <= 6'd0;
      write_position <= 6'd0;
      read_position  <= 6'd0;
      deferred_count <= 6'd0;
      armed          <= 1'b0;
      address        <= 7'd0;
    end else if (step) begin
      status         <= status_next;
      direction      <= direction_next;
      active_count   <= active_count_next;
      write_position <= write_position_next;
      read_position  <= read_position_next;
      deferred_count <= deferred_count_next;
      armed          <= armed_next;
      address        <= address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && load_ok) begin
      store[i2cms_pkg::STORE_AW'(cmd.buffer_index)] <= cmd.byte_value;
    end
  end

endmodule
